// ===== rtl/core/position_to_velocity_p_control_unit_assert.svh =====
// assertion macros for the position to velocity controller
`ifndef POSITION_TO_VELOCITY_P_CONTROL_UNIT_ASSERT_SVH
`define POSITION_TO_VELOCITY_P_CONTROL_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define P2V_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("p2v assertion failed");
`define P2V_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("p2v assertion failed");
`else
`define P2V_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define P2V_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/p2v_pkg.sv =====
// shared constants and types of the position to velocity controller
`timescale 1ns / 1ps
package p2v_pkg;
	localparam int DATA_W    = 32;
	localparam int GAIN_W    = 31;
	localparam int N_AXES    = 3;
	localparam int AXIS_Z    = 2;
	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;
	localparam int LANE_LAT  = 3;
	localparam int MERGE_LAT = 3;
	localparam int SQRT_LAT  = 32;
	localparam int DIV_STEPS = 31;
	localparam int DIV_LAT   = DIV_STEPS + 1;
	localparam int PIPE_LAT  = LANE_LAT + MERGE_LAT + SQRT_LAT + DIV_LAT + 1;

	localparam logic [2:0] REG_POSITION_GAIN  = 3'd0;
	localparam logic [2:0] REG_MAX_SPEED      = 3'd1;
	localparam logic [2:0] REG_PLANAR_MODE    = 3'd2;
	localparam logic [2:0] REG_VERTICAL_GAIN  = 3'd3;
	localparam logic [2:0] REG_VERTICAL_LIMIT = 3'd4;

	typedef struct packed {
		logic [N_AXES-1:0]             neg;
		logic                          bypass;
		logic [N_AXES-1:0][GAIN_W-1:0] red;
		logic [N_AXES-1:0][GAIN_W-1:0] direct;
	} limit_side_t;

	typedef struct packed {
		logic              neg;
		logic [GAIN_W-1:0] direct;
	} lane_side_t;
endpackage

// ===== rtl/core/p2v_stream_if.sv =====
// item channels of the position to velocity controller
`timescale 1ns / 1ps
interface p2v_sample_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] target_x;
	logic signed [31:0] target_y;
	logic signed [31:0] target_z;
	logic signed [31:0] current_x;
	logic signed [31:0] current_y;
	logic signed [31:0] current_z;
	modport source (output valid, target_x, target_y, target_z, current_x, current_y,
		current_z, input ready);
	modport sink (input valid, target_x, target_y, target_z, current_x, current_y,
		current_z, output ready);
endinterface

interface p2v_command_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [31:0] vel_z;
	logic        [31:0] error_length;
	modport source (output valid, vel_x, vel_y, vel_z, error_length, input ready);
	modport sink (input valid, vel_x, vel_y, vel_z, error_length, output ready);
endinterface

// ===== rtl/core/p2v_lane.sv =====
// one axis lane: error, gain product with rounding, squared error
`timescale 1ns / 1ps
module p2v_lane #(
	parameter int FRAC_BITS = 16,
	localparam int VW = 64 - FRAC_BITS
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [p2v_pkg::DATA_W-1:0]  target,
	input  logic signed [p2v_pkg::DATA_W-1:0]  current,
	input  logic        [p2v_pkg::GAIN_W-1:0]  gain,
	output logic                               neg_s3,
	output logic        [VW-1:0]               vmag_s3,
	output logic        [2*p2v_pkg::DATA_W:0]  esq_s3
);
	import p2v_pkg::*;

	localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

	logic signed [DATA_W:0]   err;
	logic                     neg_s1, neg_s2;
	logic        [DATA_W:0]   emag_s1;
	logic        [63:0]       prod_s2;
	logic        [2*DATA_W:0] esq_s2;

	assign err = $signed({target[DATA_W-1], target}) - $signed({current[DATA_W-1], current});

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= err[DATA_W];
			emag_s1 <= err[DATA_W] ? (DATA_W+1)'(-err) : (DATA_W+1)'(err);
			neg_s2  <= neg_s1;
			prod_s2 <= 64'(emag_s1) * 64'(gain);
			esq_s2  <= (2*DATA_W+1)'(emag_s1) * (2*DATA_W+1)'(emag_s1);
			neg_s3  <= neg_s2;
			vmag_s3 <= VW'((prod_s2 + HALF) >> FRAC_BITS);
			esq_s3  <= esq_s2;
		end
	end
endmodule

// ===== rtl/core/p2v_isqrt.sv =====
// pipelined floor square root of a 64-bit value, one root bit per stage
`timescale 1ns / 1ps
module p2v_isqrt #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              en,
	input  logic [63:0]       x_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic [31:0]       root,
	output logic [SIDE_W-1:0] side_out
);
	import p2v_pkg::*;

	logic [63:0]       x_s    [SQRT_LAT];
	logic [63:0]       r_s    [SQRT_LAT];
	logic [SIDE_W-1:0] side_s [SQRT_LAT];
	logic [63:0]       x_n    [SQRT_LAT];
	logic [63:0]       r_n    [SQRT_LAT];
	logic [SIDE_W-1:0] side_n [SQRT_LAT];

	always_comb begin
		logic [63:0] xi, ri, b, t;
		for (int k = 0; k < SQRT_LAT; k++) begin
			if (k == 0) begin
				xi        = x_in;
				ri        = '0;
				side_n[k] = side_in;
			end else begin
				xi        = x_s[k-1];
				ri        = r_s[k-1];
				side_n[k] = side_s[k-1];
			end
			b = 64'd1 << (62 - 2 * k);
			t = ri + b;
			if (xi >= t) begin
				x_n[k] = xi - t;
				r_n[k] = (ri >> 1) + b;
			end else begin
				x_n[k] = xi;
				r_n[k] = ri >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s    <= x_n;
			r_s    <= r_n;
			side_s <= side_n;
		end
	end

	assign root     = r_s[SQRT_LAT-1][31:0];
	assign side_out = side_s[SQRT_LAT-1];
endmodule

// ===== rtl/core/p2v_div.sv =====
// lane rescale: speed limit times reduced magnitude, then pipelined long division
`timescale 1ns / 1ps
module p2v_div #(
	parameter int SIDE_W = 1
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [p2v_pkg::GAIN_W-1:0] a,
	input  logic [p2v_pkg::GAIN_W-1:0] m,
	input  logic [31:0]                d,
	input  logic [SIDE_W-1:0]          side_in,
	output logic [p2v_pkg::GAIN_W-1:0] quot,
	output logic [SIDE_W-1:0]          side_out
);
	import p2v_pkg::*;

	logic [2*GAIN_W-1:0] num_s1;
	logic [31:0]         d_s1;
	logic [SIDE_W-1:0]   side_s1;

	// remainder, and low numerator bits that turn into quotient bits
	logic [31:0]       rem_s  [DIV_STEPS];
	logic [GAIN_W-1:0] lq_s   [DIV_STEPS];
	logic [31:0]       d_s    [DIV_STEPS];
	logic [SIDE_W-1:0] side_s [DIV_STEPS];
	logic [31:0]       rem_n  [DIV_STEPS];
	logic [GAIN_W-1:0] lq_n   [DIV_STEPS];
	logic [31:0]       d_n    [DIV_STEPS];
	logic [SIDE_W-1:0] side_n [DIV_STEPS];

	always_comb begin
		logic [31:0]       ri;
		logic [GAIN_W-1:0] li;
		logic [32:0]       r2;
		logic              ge;
		for (int j = 0; j < DIV_STEPS; j++) begin
			if (j == 0) begin
				ri        = {1'b0, num_s1[2*GAIN_W-1:GAIN_W]};
				li        = num_s1[GAIN_W-1:0];
				d_n[j]    = d_s1;
				side_n[j] = side_s1;
			end else begin
				ri        = rem_s[j-1];
				li        = lq_s[j-1];
				d_n[j]    = d_s[j-1];
				side_n[j] = side_s[j-1];
			end
			r2       = {ri, li[GAIN_W-1]};
			ge       = r2 >= {1'b0, d_n[j]};
			rem_n[j] = ge ? 32'(r2 - {1'b0, d_n[j]}) : 32'(r2);
			lq_n[j]  = {li[GAIN_W-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1  <= (2*GAIN_W)'(a) * (2*GAIN_W)'(m);
			d_s1    <= d;
			side_s1 <= side_in;
			rem_s   <= rem_n;
			lq_s    <= lq_n;
			d_s     <= d_n;
			side_s  <= side_n;
		end
	end

	assign quot     = lq_s[DIV_STEPS-1];
	assign side_out = side_s[DIV_STEPS-1];
endmodule

// ===== rtl/core/position_to_velocity_p_control_unit.sv =====
// top level: proportional position controller with velocity length limit
//
// channel   dir  handshake          payload
// sample    in   valid/ready        target_x/y/z, current_x/y/z
// command   out  valid/ready        vel_x/y/z, error_length
// apb       in   psel/penable       position_gain, max_speed, planar_mode,
//                                   vertical_gain, vertical_limit
//
// one item per cycle while the pipeline advances; a new item may enter before earlier ones finish
// latency is set by the two 32-stage square root pipes and the 31-step dividers
// whole pipeline stalls together when a result waits and command.ready is low
// arst_n clears the valid chain and loads the register defaults
`timescale 1ns / 1ps
`include "position_to_velocity_p_control_unit_assert.svh"
module position_to_velocity_p_control_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	p2v_sample_if.sink                 sample,
	p2v_command_if.source              command,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [p2v_pkg::APB_AW-1:0] paddr,
	input  logic [p2v_pkg::APB_DW-1:0] pwdata,
	output logic [p2v_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import p2v_pkg::*;

	localparam int VW = 64 - FRAC_BITS;
	localparam int HW = VW - GAIN_W;
	localparam int SW = $clog2(HW + 1);
	localparam logic [GAIN_W-1:0] GAIN_RST  = GAIN_W'(64'd4 << FRAC_BITS);
	localparam logic [GAIN_W-1:0] VGAIN_RST = GAIN_W'(64'd3 << (FRAC_BITS - 1));
	localparam logic [GAIN_W-1:0] VLIM_RST  = GAIN_W'(64'd1 << FRAC_BITS);
	localparam int LSIDE_W = $bits(lane_side_t);
	localparam int XSIDE_W = $bits(limit_side_t);

	typedef struct packed {
		logic        bypass;
		logic [31:0] errlen;
	} misc_t;

	// configuration registers
	logic [GAIN_W-1:0] position_gain_q, max_speed_q, vertical_gain_q, vertical_limit_q;
	logic              planar_q;
	logic              cfg_wr;
	logic [2:0]        cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[APB_AW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_gain_q  <= GAIN_RST;
			max_speed_q      <= '0;
			planar_q         <= 1'b1;
			vertical_gain_q  <= VGAIN_RST;
			vertical_limit_q <= VLIM_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_POSITION_GAIN:  position_gain_q  <= pwdata[GAIN_W-1:0];
				REG_MAX_SPEED:      max_speed_q      <= pwdata[GAIN_W-1:0];
				REG_PLANAR_MODE:    planar_q         <= pwdata[0];
				REG_VERTICAL_GAIN:  vertical_gain_q  <= pwdata[GAIN_W-1:0];
				REG_VERTICAL_LIMIT: vertical_limit_q <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_POSITION_GAIN:  prdata = APB_DW'(position_gain_q);
			REG_MAX_SPEED:      prdata = APB_DW'(max_speed_q);
			REG_PLANAR_MODE:    prdata = APB_DW'(planar_q);
			REG_VERTICAL_GAIN:  prdata = APB_DW'(vertical_gain_q);
			REG_VERTICAL_LIMIT: prdata = APB_DW'(vertical_limit_q);
			default:            prdata = '0;
		endcase
	end

	// valid chain and global advance
	logic [PIPE_LAT-1:0] vld_q;
	logic                adv;

	assign adv           = !vld_q[PIPE_LAT-1] || command.ready;
	assign sample.ready  = adv;
	assign command.valid = vld_q[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], sample.valid};
		end
	end

	// axis lanes
	logic signed [DATA_W-1:0] tgt [N_AXES];
	logic signed [DATA_W-1:0] cur [N_AXES];
	logic                     neg_s3  [N_AXES];
	logic [VW-1:0]            vmag_s3 [N_AXES];
	logic [2*DATA_W:0]        esq_s3  [N_AXES];

	assign tgt[0] = sample.target_x;
	assign tgt[1] = sample.target_y;
	assign tgt[2] = sample.target_z;
	assign cur[0] = sample.current_x;
	assign cur[1] = sample.current_y;
	assign cur[2] = sample.current_z;

	for (genvar i = 0; i < N_AXES; i++) begin : g_lane
		p2v_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk     (clk),
			.en      (adv),
			.target  (tgt[i]),
			.current (cur[i]),
			.gain    ((planar_q && i == AXIS_Z) ? vertical_gain_q : position_gain_q),
			.neg_s3  (neg_s3[i]),
			.vmag_s3 (vmag_s3[i]),
			.esq_s3  (esq_s3[i])
		);
	end

	// merge stage 4: common shift, vertical clamp, error sum
	logic [HW-1:0]     hi;
	logic [SW-1:0]     sh;
	logic [GAIN_W-1:0] red_c    [N_AXES];
	logic [GAIN_W-1:0] direct_c [N_AXES];
	logic [2*DATA_W+2:0] esum_c;

	always_comb begin
		hi = vmag_s3[0][VW-1:GAIN_W] | vmag_s3[1][VW-1:GAIN_W]
			| (planar_q ? HW'(0) : vmag_s3[AXIS_Z][VW-1:GAIN_W]);
		sh = '0;
		for (int b = 0; b < HW; b++) begin
			if (hi[b]) sh = SW'(b + 1);
		end
		for (int i = 0; i < N_AXES; i++) begin
			red_c[i] = GAIN_W'(vmag_s3[i] >> sh);
			if (planar_q && i == AXIS_Z && vmag_s3[i] > VW'(vertical_limit_q)) begin
				direct_c[i] = vertical_limit_q;
			end else begin
				direct_c[i] = vmag_s3[i][GAIN_W-1:0];
			end
		end
		esum_c = (2*DATA_W+3)'(esq_s3[0]) + (2*DATA_W+3)'(esq_s3[1])
			+ (planar_q ? '0 : (2*DATA_W+3)'(esq_s3[AXIS_Z]));
	end

	logic [GAIN_W-1:0]   red_s4    [N_AXES];
	logic [GAIN_W-1:0]   direct_s4 [N_AXES];
	logic [N_AXES-1:0]   neg_s4, neg_s5;
	logic                shifted_s4, shifted_s5;
	logic [63:0]         esum_s4, esum_s5, esum_s6;
	logic                esat_s4, esat_s5, esat_s6;
	logic [GAIN_W-1:0]   red_s5    [N_AXES];
	logic [GAIN_W-1:0]   direct_s5 [N_AXES];
	logic [2*GAIN_W-1:0] rsq_s5    [N_AXES];
	logic [2*GAIN_W-1:0] vsq_s5;
	logic [63:0]         rsum_c, rsum_s6;
	limit_side_t         side_s6;

	assign rsum_c = 64'(rsq_s5[0]) + 64'(rsq_s5[1])
		+ (planar_q ? 64'd0 : 64'(rsq_s5[AXIS_Z]));

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < N_AXES; i++) begin
				red_s4[i]    <= red_c[i];
				direct_s4[i] <= direct_c[i];
				neg_s4[i]    <= neg_s3[i];
				red_s5[i]    <= red_s4[i];
				direct_s5[i] <= direct_s4[i];
				rsq_s5[i]    <= (2*GAIN_W)'(red_s4[i]) * (2*GAIN_W)'(red_s4[i]);
				side_s6.red[i]    <= red_s5[i];
				side_s6.direct[i] <= direct_s5[i];
			end
			shifted_s4 <= |hi;
			esum_s4    <= esum_c[63:0];
			esat_s4    <= |esum_c[2*DATA_W+2:64];
			neg_s5     <= neg_s4;
			shifted_s5 <= shifted_s4;
			esum_s5    <= esum_s4;
			esat_s5    <= esat_s4;
			vsq_s5     <= (2*GAIN_W)'(max_speed_q) * (2*GAIN_W)'(max_speed_q);
			rsum_s6    <= rsum_c;
			esum_s6    <= esum_s5;
			esat_s6    <= esat_s5;
			side_s6.neg    <= neg_s5;
			side_s6.bypass <= !shifted_s5 && (rsum_c <= 64'(vsq_s5));
		end
	end

	// square roots of the command length and the error length
	logic [31:0]        len_root, err_root;
	logic [XSIDE_W-1:0] xside_raw;
	limit_side_t        xside;
	logic               esat_o;

	p2v_isqrt #(.SIDE_W(XSIDE_W)) u_len_sqrt (
		.clk      (clk),
		.en       (adv),
		.x_in     (rsum_s6),
		.side_in  (side_s6),
		.root     (len_root),
		.side_out (xside_raw)
	);

	p2v_isqrt #(.SIDE_W(1)) u_err_sqrt (
		.clk      (clk),
		.en       (adv),
		.x_in     (esum_s6),
		.side_in  (esat_s6),
		.root     (err_root),
		.side_out (esat_o)
	);

	assign xside = limit_side_t'(xside_raw);

	// per-lane rescale
	logic [31:0]        len_c;
	logic [GAIN_W-1:0]  quot      [N_AXES];
	logic [LSIDE_W-1:0] lside_raw [N_AXES];
	lane_side_t         lside     [N_AXES];

	assign len_c = (len_root == '0) ? 32'd1 : len_root;

	for (genvar i = 0; i < N_AXES; i++) begin : g_div
		p2v_div #(.SIDE_W(LSIDE_W)) u_div (
			.clk      (clk),
			.en       (adv),
			.a        (max_speed_q),
			.m        (xside.red[i]),
			.d        (len_c),
			.side_in  ({xside.neg[i], xside.direct[i]}),
			.quot     (quot[i]),
			.side_out (lside_raw[i])
		);
		assign lside[i] = lane_side_t'(lside_raw[i]);
	end

	misc_t misc_q [DIV_LAT];

	always_ff @(posedge clk) begin
		if (adv) begin
			misc_q[0].bypass <= xside.bypass;
			misc_q[0].errlen <= esat_o ? '1 : err_root;
			for (int k = 1; k < DIV_LAT; k++) begin
				misc_q[k] <= misc_q[k-1];
			end
		end
	end

	// output register
	logic [DATA_W-1:0] vel_c [N_AXES];
	logic [DATA_W-1:0] vel_q [N_AXES];
	logic [31:0]       errlen_q;

	always_comb begin
		logic [GAIN_W-1:0] mag;
		for (int i = 0; i < N_AXES; i++) begin
			if ((planar_q && i == AXIS_Z) || misc_q[DIV_LAT-1].bypass) begin
				mag = lside[i].direct;
			end else begin
				mag = quot[i];
			end
			vel_c[i] = lside[i].neg ? (DATA_W'(0) - DATA_W'(mag)) : DATA_W'(mag);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vel_q    <= vel_c;
			errlen_q <= misc_q[DIV_LAT-1].errlen;
		end
	end

	assign command.vel_x        = vel_q[0];
	assign command.vel_y        = vel_q[1];
	assign command.vel_z        = vel_q[AXIS_Z];
	assign command.error_length = errlen_q;

	`P2V_ASSERT_NEXT(a_item_enters, clk, arst_n, sample.valid && sample.ready, vld_q[0])
	`P2V_ASSERT_IMP(a_quot_bound, clk, arst_n, vld_q[PIPE_LAT-2],
		quot[0] <= max_speed_q && quot[1] <= max_speed_q
		&& (planar_q || quot[AXIS_Z] <= max_speed_q))
	`P2V_ASSERT_IMP(a_vert_clamp, clk, arst_n, command.valid && planar_q,
		(command.vel_z[31] ? 32'(-command.vel_z) : 32'(command.vel_z))
		<= 32'(vertical_limit_q))
endmodule
